@@ rtl/avr_pkg.sv @@
`timescale 1ns / 1ps

package avr_pkg;

    // One vector transfer after the angle has been reduced to a right angle
    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [29:0] ang;     // residual angle, degrees Q.20
        logic               flip;    // angle folded by a half turn
    } t_item;

    localparam int ATAN_LEN = 24;

    // atan(2^-i) in degrees, Q.20, rounded to nearest
    localparam logic [25:0] ATAN_Q20 [ATAN_LEN] = '{
        26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121,
        26'd3750058,  26'd1876857,  26'd938658,   26'd469357,
        26'd234682,   26'd117342,   26'd58671,    26'd29335,
        26'd14668,    26'd7334,     26'd3667,     26'd1833,
        26'd917,      26'd458,      26'd229,      26'd115,
        26'd57,       26'd29,       26'd14,       26'd7
    };

    // Angle steps (input LSB = 1/64 degree)
    localparam logic signed [16:0] TURN_STEPS    = 17'sd23040;
    localparam logic signed [16:0] HALF_STEPS    = 17'sd11520;
    localparam logic signed [16:0] QUARTER_STEPS = 17'sd5760;

    // CORDIC gain in Q30
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

endpackage

@@ rtl/axis_angle_vector_rotate_core.sv @@
`timescale 1ns / 1ps

// Rotates a Q16.16 vector about a Q1.14 unit axis by an angle in Q9.6 degrees.
// Input channel: drive the fields and raise start; the transfer happens at a
// rising edge with start high and busy low. busy stays low in normal use,
// so one vector can be transferred on every clock.
// Output channel: o_valid strobes for exactly one cycle with o_rot_x/y/z;
// the receiver cannot hold results off and none is dropped.
// On its way to the ports a result passes the front register, the queue, the
// CORDIC input register, CORDIC_STEPS micro-rotation stages and five matrix
// stages. Throughput: one item per cycle, set by the fully pipelined CORDIC
// and the per-stage multipliers.
// A front stage reduces and folds the angle; a two-entry queue feeds the
// back pipeline, which drains it every cycle.
// Reset (synchronous, active low) clears all valid flags and the queue;
// items in flight are discarded. No clearing pass is needed.

module axis_angle_vector_rotate_core #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  i_vec_x,
    input  logic signed [31:0]  i_vec_y,
    input  logic signed [31:0]  i_vec_z,
    input  logic signed [15:0]  i_axis_x,
    input  logic signed [15:0]  i_axis_y,
    input  logic signed [15:0]  i_axis_z,
    input  logic signed [15:0]  i_angle_deg,
    output logic                o_valid,
    output logic signed [31:0]  o_rot_x,
    output logic signed [31:0]  o_rot_y,
    output logic signed [31:0]  o_rot_z
);

    localparam int unsigned LAT = CORDIC_STEPS + 8;

    logic           q_full;
    logic           q_wr;
    avr_pkg::t_item q_wdata;
    logic           q_valid;
    avr_pkg::t_item q_rdata;

    avr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .i_axis_x    (i_axis_x),
        .i_axis_y    (i_axis_y),
        .i_axis_z    (i_axis_z),
        .i_angle_deg (i_angle_deg),
        .i_q_full    (q_full),
        .o_q_wr      (q_wr),
        .o_q_data    (q_wdata)
    );

    avr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    avr_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_rdata),
        .o_valid (o_valid),
        .o_rot_x (o_rot_x),
        .o_rot_y (o_rot_y),
        .o_rot_z (o_rot_z)
    );

    // Every transfer yields a result after the fixed pipeline latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing after transfer");

    // The back end drains the queue every cycle, so it never fills
    a_no_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_full)
        else $error("queue filled up");

    // A queue write only happens while the front holds an item and input is open
    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |-> !busy)
        else $error("queue write while busy");

endmodule

@@ rtl/avr_front.sv @@
`timescale 1ns / 1ps

module avr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic signed [31:0]   i_vec_x,
    input  logic signed [31:0]   i_vec_y,
    input  logic signed [31:0]   i_vec_z,
    input  logic signed [15:0]   i_axis_x,
    input  logic signed [15:0]   i_axis_y,
    input  logic signed [15:0]   i_axis_z,
    input  logic signed [15:0]   i_angle_deg,
    input  logic                 i_q_full,
    output logic                 o_q_wr,
    output avr_pkg::t_item       o_q_data
);

    logic               r_vld;
    logic               n_vld;
    avr_pkg::t_item     r_item;
    logic               accept;
    logic signed [16:0] ang_in;
    logic signed [16:0] ang_turn;
    logic signed [16:0] ang_fold;
    logic               fold;

    assign o_busy   = r_vld && i_q_full;
    assign accept   = i_start && !o_busy;
    assign o_q_wr   = r_vld && !i_q_full;
    assign o_q_data = r_item;

    // Reduce to (-180, 180] degrees, then fold into [-90, 90]
    always_comb begin
        ang_in = 17'(i_angle_deg);
        if (ang_in > avr_pkg::HALF_STEPS) begin
            ang_turn = ang_in - avr_pkg::TURN_STEPS;
        end else if (ang_in <= -avr_pkg::HALF_STEPS) begin
            ang_turn = ang_in + avr_pkg::TURN_STEPS;
        end else begin
            ang_turn = ang_in;
        end
        fold     = 1'b0;
        ang_fold = ang_turn;
        if (ang_turn > avr_pkg::QUARTER_STEPS) begin
            ang_fold = ang_turn - avr_pkg::HALF_STEPS;
            fold     = 1'b1;
        end else if (ang_turn < -avr_pkg::QUARTER_STEPS) begin
            ang_fold = ang_turn + avr_pkg::HALF_STEPS;
            fold     = 1'b1;
        end
    end

    // Holding register valid: load on transfer, clear when queue takes it
    always_comb begin
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_q_wr) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.vec_x  <= i_vec_x;
            r_item.vec_y  <= i_vec_y;
            r_item.vec_z  <= i_vec_z;
            r_item.axis_x <= i_axis_x;
            r_item.axis_y <= i_axis_y;
            r_item.axis_z <= i_axis_z;
            r_item.ang    <= 30'(ang_fold) <<< 14;
            r_item.flip   <= fold;
        end
    end

endmodule

@@ rtl/avr_queue.sv @@
`timescale 1ns / 1ps

module avr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  avr_pkg::t_item  i_data,
    output logic            o_full,
    output logic            o_valid,
    output avr_pkg::t_item  o_data
);

    avr_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign rd      = o_valid;        // back end never stalls
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt + 2'(i_wr) - 2'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/avr_back.sv @@
`timescale 1ns / 1ps

module avr_back #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  avr_pkg::t_item      i_item,
    output logic                o_valid,
    output logic signed [31:0]  o_rot_x,
    output logic signed [31:0]  o_rot_y,
    output logic signed [31:0]  o_rot_z
);

    localparam logic signed [65:0] MAT_RND = 66'sd1 <<< 33;
    localparam logic signed [65:0] OUT_RND = 66'sd1 <<< 23;
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1 <<< 30;

    // CORDIC pipeline, one micro-rotation per stage
    avr_pkg::t_item     r_pl [0:CORDIC_STEPS];
    logic signed [32:0] r_x  [0:CORDIC_STEPS];
    logic signed [32:0] r_y  [0:CORDIC_STEPS];
    logic               r_v  [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pl[0] <= i_item;
        r_x[0]  <= avr_pkg::CORDIC_GAIN_Q30;
        r_y[0]  <= 33'sd0;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        avr_pkg::t_item     n_pl;
        logic signed [29:0] atan_i;
        logic signed [32:0] dx;
        logic signed [32:0] dy;

        assign atan_i = $signed({4'b0, avr_pkg::ATAN_Q20[i]});
        assign dx     = r_y[i] >>> i;
        assign dy     = r_x[i] >>> i;

        always_comb begin
            n_pl = r_pl[i];
            if (r_pl[i].ang >= 0) begin
                n_pl.ang = r_pl[i].ang - atan_i;
            end else begin
                n_pl.ang = r_pl[i].ang + atan_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_pl[i+1] <= n_pl;
            if (r_pl[i].ang >= 0) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
            end
        end
    end

    // Stage A: sign fix, 1-c, axis products, axis*sine
    logic               r_va;
    logic signed [32:0] r_c;
    logic signed [33:0] r_omc;
    logic signed [31:0] r_pxx, r_pxy, r_pxz, r_pyy, r_pyz, r_pzz;
    logic signed [48:0] r_sx, r_sy, r_sz;
    logic signed [31:0] r_vxa, r_vya, r_vza;
    logic signed [32:0] c_fix;
    logic signed [32:0] s_fix;
    avr_pkg::t_item     last;

    assign last  = r_pl[CORDIC_STEPS];
    assign c_fix = last.flip ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
    assign s_fix = last.flip ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        r_c   <= c_fix;
        r_omc <= ONE_Q30 - 34'(c_fix);
        r_pxx <= 32'(last.axis_x) * 32'(last.axis_x);
        r_pxy <= 32'(last.axis_x) * 32'(last.axis_y);
        r_pxz <= 32'(last.axis_x) * 32'(last.axis_z);
        r_pyy <= 32'(last.axis_y) * 32'(last.axis_y);
        r_pyz <= 32'(last.axis_y) * 32'(last.axis_z);
        r_pzz <= 32'(last.axis_z) * 32'(last.axis_z);
        r_sx  <= 49'(last.axis_x) * 49'(s_fix);
        r_sy  <= 49'(last.axis_y) * 49'(s_fix);
        r_sz  <= 49'(last.axis_z) * 49'(s_fix);
        r_vxa <= last.vec_x;
        r_vya <= last.vec_y;
        r_vza <= last.vec_z;
    end

    // Stage B: axis products times (1-c), cosine and axis*sine terms aligned to Q58
    logic               r_vb;
    logic signed [65:0] r_qxx, r_qxy, r_qxz, r_qyy, r_qyz, r_qzz;
    logic signed [65:0] r_c58, r_sx58, r_sy58, r_sz58;
    logic signed [31:0] r_vxb, r_vyb, r_vzb;

    always_ff @(posedge i_clk) begin
        r_qxx  <= 66'(r_pxx) * 66'(r_omc);
        r_qxy  <= 66'(r_pxy) * 66'(r_omc);
        r_qxz  <= 66'(r_pxz) * 66'(r_omc);
        r_qyy  <= 66'(r_pyy) * 66'(r_omc);
        r_qyz  <= 66'(r_pyz) * 66'(r_omc);
        r_qzz  <= 66'(r_pzz) * 66'(r_omc);
        r_c58  <= 66'(r_c) <<< 28;
        r_sx58 <= 66'(r_sx) <<< 14;
        r_sy58 <= 66'(r_sy) <<< 14;
        r_sz58 <= 66'(r_sz) <<< 14;
        r_vxb  <= r_vxa;
        r_vyb  <= r_vya;
        r_vzb  <= r_vza;
    end

    // Stage C: matrix entries rounded to Q24
    logic               r_vc;
    logic signed [31:0] r_m00, r_m01, r_m02, r_m10, r_m11, r_m12, r_m20, r_m21, r_m22;
    logic signed [31:0] r_vxc, r_vyc, r_vzc;
    logic signed [65:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;

    always_comb begin
        e00 = (r_qxx + r_c58  + MAT_RND) >>> 34;
        e01 = (r_qxy - r_sz58 + MAT_RND) >>> 34;
        e02 = (r_qxz + r_sy58 + MAT_RND) >>> 34;
        e10 = (r_qxy + r_sz58 + MAT_RND) >>> 34;
        e11 = (r_qyy + r_c58  + MAT_RND) >>> 34;
        e12 = (r_qyz - r_sx58 + MAT_RND) >>> 34;
        e20 = (r_qxz - r_sy58 + MAT_RND) >>> 34;
        e21 = (r_qyz + r_sx58 + MAT_RND) >>> 34;
        e22 = (r_qzz + r_c58  + MAT_RND) >>> 34;
    end

    always_ff @(posedge i_clk) begin
        r_m00 <= e00[31:0];
        r_m01 <= e01[31:0];
        r_m02 <= e02[31:0];
        r_m10 <= e10[31:0];
        r_m11 <= e11[31:0];
        r_m12 <= e12[31:0];
        r_m20 <= e20[31:0];
        r_m21 <= e21[31:0];
        r_m22 <= e22[31:0];
        r_vxc <= r_vxb;
        r_vyc <= r_vyb;
        r_vzc <= r_vzb;
    end

    // Stage D: vector times matrix, nine products
    logic               r_vd;
    logic signed [63:0] r_p00, r_p01, r_p02, r_p10, r_p11, r_p12, r_p20, r_p21, r_p22;

    always_ff @(posedge i_clk) begin
        r_p00 <= 64'(r_vxc) * 64'(r_m00);
        r_p01 <= 64'(r_vyc) * 64'(r_m01);
        r_p02 <= 64'(r_vzc) * 64'(r_m02);
        r_p10 <= 64'(r_vxc) * 64'(r_m10);
        r_p11 <= 64'(r_vyc) * 64'(r_m11);
        r_p12 <= 64'(r_vzc) * 64'(r_m12);
        r_p20 <= 64'(r_vxc) * 64'(r_m20);
        r_p21 <= 64'(r_vyc) * 64'(r_m21);
        r_p22 <= 64'(r_vzc) * 64'(r_m22);
    end

    // Stage E: row sums, round, saturate
    logic signed [65:0] acc_x, acc_y, acc_z;
    logic               r_ve;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] t;
        begin
            t = v;
            if (v > SAT_MAX) begin
                t = SAT_MAX;
            end else if (v < SAT_MIN) begin
                t = SAT_MIN;
            end
            return t[31:0];
        end
    endfunction

    always_comb begin
        acc_x = (66'(r_p00) + 66'(r_p01) + 66'(r_p02) + OUT_RND) >>> 24;
        acc_y = (66'(r_p10) + 66'(r_p11) + 66'(r_p12) + OUT_RND) >>> 24;
        acc_z = (66'(r_p20) + 66'(r_p21) + 66'(r_p22) + OUT_RND) >>> 24;
    end

    always_ff @(posedge i_clk) begin
        o_rot_x <= sat32(acc_x);
        o_rot_y <= sat32(acc_y);
        o_rot_z <= sat32(acc_z);
    end

    // Valid pipeline for the back stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            r_va <= r_v[CORDIC_STEPS];
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    assign o_valid = r_ve;

endmodule
